### src/rect_blit_with_key_modes_assert.svh
// assertion macros for the rectangle blitter
`ifndef RECT_BLIT_WITH_KEY_MODES_ASSERT_SVH
`define RECT_BLIT_WITH_KEY_MODES_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define RBK_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbk assertion failed");

// antecedent implies consequent in the next cycle
`define RBK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbk assertion failed");

`else

`define RBK_ASSERT_SAME(label, ante, cons)
`define RBK_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### src/rbk_pkg.sv
// shared types and constants for the rectangle blitter
package rbk_pkg;

  localparam int unsigned LINE_PITCH = 320;

  localparam int unsigned ADDR_W     = 20;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned WIDTH_W    = 9;
  localparam int unsigned HEIGHT_W   = 8;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [PIX_W-1:0] KEY_LIMIT = 8'd200;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DST_START,
    REG_SRC_START,
    REG_RECT_WIDTH,
    REG_RECT_HEIGHT,
    REG_BLIT_MODE,
    REG_WINDOW_COL,
    REG_WINDOW_ROW
  } rbk_reg_t;

  typedef enum logic [1:0] {
    MODE_COPY,
    MODE_KEY_BELOW,
    MODE_ZERO_KEY,
    MODE_WINDOW
  } rbk_mode_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dst_addr;
    logic [ADDR_W-1:0] src_addr;
    logic              write_enable;
    logic [PIX_W-1:0]  write_data;
    logic              last_pixel;
  } rbk_result_t;

endpackage

### src/rbk_if.sv
// valid/ready channel interfaces for pixel input and result output
interface rbk_in_if;
  logic                       valid;
  logic                       ready;
  logic [rbk_pkg::PIX_W-1:0]  src_pixel;
  logic [rbk_pkg::PIX_W-1:0]  old_dst_pixel;

  modport source (output valid, output src_pixel, output old_dst_pixel, input ready);
  modport sink   (input valid, input src_pixel, input old_dst_pixel, output ready);
endinterface

interface rbk_out_if;
  logic                       valid;
  logic                       ready;
  logic [rbk_pkg::ADDR_W-1:0] dst_addr;
  logic [rbk_pkg::ADDR_W-1:0] src_addr;
  logic                       write_enable;
  logic [rbk_pkg::PIX_W-1:0]  write_data;
  logic                       last_pixel;

  modport source (output valid, output dst_addr, output src_addr, output write_enable,
                  output write_data, output last_pixel, input ready);
  modport sink   (input valid, input dst_addr, input src_addr, input write_enable,
                  input write_data, input last_pixel, output ready);
endinterface

### src/rect_blit_with_key_modes.sv
// rectangle blitter top level: address walk, key decision and output skid buffer
//
// Usage: program the seven registers through cfg_write/cfg_index/cfg_data while
// the block is idle; any write restarts the walk at the first pixel. Index 7 is
// ignored. For each pixel the caller fetches the source and destination bytes
// and presents them on pixel_in; result_out returns the destination and source
// addresses of that pixel, the write decision, the byte to write and a flag on
// the last pixel of the rectangle. After the last pixel the walk starts over.
// Results are registered in the output register, or the skid register on a stall.
// Throughput: one pixel per cycle while the receiver takes results, set by the
// single registered pass from the pixel state to the result register.
// Reset clears the registers to dst 0, src 0, 1x1 rectangle, copy mode, and
// puts the walk at the first pixel.
// When the receiver stalls, one more input transaction is taken into a skid
// register; pixel_in.ready then drops until the skid entry has moved out.
`include "rect_blit_with_key_modes_assert.svh"

module rect_blit_with_key_modes (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rbk_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rbk_pkg::CFG_DATA_W-1:0]  cfg_data,
  rbk_in_if.sink                          pixel_in,
  rbk_out_if.source                       result_out
);

  localparam int unsigned AW = rbk_pkg::ADDR_W;
  localparam int unsigned WW = rbk_pkg::WIDTH_W;
  localparam int unsigned HW = rbk_pkg::HEIGHT_W;

  // configuration registers
  logic [AW-1:0]      dst_start, dst_start_next;
  logic [AW-1:0]      src_start, src_start_next;
  logic [WW-1:0]      rect_width, rect_width_next;
  logic [HW-1:0]      rect_height, rect_height_next;
  rbk_pkg::rbk_mode_t blit_mode, blit_mode_next;
  logic [WW-1:0]      window_col, window_col_next;
  logic [HW-1:0]      window_row, window_row_next;
  logic               cfg_hit;

  // walk state
  logic [WW-1:0] column_count;
  logic [HW-1:0] row_count;
  logic [AW-1:0] dst_pointer;
  logic [AW-1:0] src_pointer;

  logic [AW-1:0] restart_src;
  logic [AW-1:0] window_offset;
  logic [WW-1:0] eff_width;
  logic [HW-1:0] eff_height;
  logic [AW-1:0] row_skip;
  logic          row_end;
  logic          rect_end;
  logic          in_acc;
  logic          out_free;

  rbk_pkg::rbk_result_t result_new;
  rbk_pkg::rbk_result_t out_reg;
  rbk_pkg::rbk_result_t skid;
  logic                 out_valid;
  logic                 skid_valid;

  always_comb begin
    dst_start_next   = dst_start;
    src_start_next   = src_start;
    rect_width_next  = rect_width;
    rect_height_next = rect_height;
    blit_mode_next   = blit_mode;
    window_col_next  = window_col;
    window_row_next  = window_row;
    cfg_hit          = 1'b0;
    if (cfg_write) begin
      cfg_hit = 1'b1;
      case (cfg_index)
        rbk_pkg::REG_DST_START:   dst_start_next   = cfg_data[AW-1:0];
        rbk_pkg::REG_SRC_START:   src_start_next   = cfg_data[AW-1:0];
        rbk_pkg::REG_RECT_WIDTH:  rect_width_next  = cfg_data[WW-1:0];
        rbk_pkg::REG_RECT_HEIGHT: rect_height_next = cfg_data[HW-1:0];
        rbk_pkg::REG_BLIT_MODE:   blit_mode_next   = rbk_pkg::rbk_mode_t'(cfg_data[1:0]);
        rbk_pkg::REG_WINDOW_COL:  window_col_next  = cfg_data[WW-1:0];
        rbk_pkg::REG_WINDOW_ROW:  window_row_next  = cfg_data[HW-1:0];
        default:                  cfg_hit          = 1'b0;
      endcase
    end
  end

  // source start of the walk, offset into the window in windowed mode
  always_comb begin
    window_offset = AW'(AW'(window_row_next) * AW'(rbk_pkg::LINE_PITCH))
                  + AW'(window_col_next);
    restart_src   = src_start_next;
    if (blit_mode_next == rbk_pkg::MODE_WINDOW) begin
      restart_src = src_start_next + window_offset;
    end
  end

  always_comb begin
    eff_width  = (rect_width == '0) ? WW'(1) : rect_width;
    eff_height = (rect_height == '0) ? HW'(1) : rect_height;
    row_skip   = AW'(rbk_pkg::LINE_PITCH) - AW'(eff_width);
    row_end    = ({1'b0, column_count} + (WW+1)'(1)) >= {1'b0, eff_width};
    rect_end   = row_end && (({1'b0, row_count} + (HW+1)'(1)) >= {1'b0, eff_height});
  end

  // result of the current pixel
  always_comb begin
    result_new.dst_addr     = dst_pointer;
    result_new.src_addr     = src_pointer;
    result_new.write_data   = pixel_in.src_pixel;
    result_new.last_pixel   = rect_end;
    case (blit_mode)
      rbk_pkg::MODE_KEY_BELOW: result_new.write_enable = pixel_in.old_dst_pixel < rbk_pkg::KEY_LIMIT;
      rbk_pkg::MODE_ZERO_KEY:  result_new.write_enable = pixel_in.src_pixel != '0;
      default:                 result_new.write_enable = 1'b1;
    endcase
  end

  assign pixel_in.ready = !skid_valid;
  assign in_acc         = pixel_in.valid && !skid_valid;
  assign out_free       = !out_valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_start    <= '0;
      src_start    <= '0;
      rect_width   <= WW'(1);
      rect_height  <= HW'(1);
      blit_mode    <= rbk_pkg::MODE_COPY;
      window_col   <= '0;
      window_row   <= '0;
      column_count <= '0;
      row_count    <= '0;
      dst_pointer  <= '0;
      src_pointer  <= '0;
    end else begin
      dst_start   <= dst_start_next;
      src_start   <= src_start_next;
      rect_width  <= rect_width_next;
      rect_height <= rect_height_next;
      blit_mode   <= blit_mode_next;
      window_col  <= window_col_next;
      window_row  <= window_row_next;
      if (cfg_hit || (in_acc && rect_end)) begin
        column_count <= '0;
        row_count    <= '0;
        dst_pointer  <= dst_start_next;
        src_pointer  <= restart_src;
      end else if (in_acc) begin
        if (row_end) begin
          column_count <= '0;
          row_count    <= row_count + HW'(1);
          dst_pointer  <= dst_pointer + AW'(1) + row_skip;
          if (blit_mode == rbk_pkg::MODE_WINDOW) begin
            src_pointer <= src_pointer + AW'(1) + row_skip;
          end else begin
            src_pointer <= src_pointer + AW'(1);
          end
        end else begin
          column_count <= column_count + WW'(1);
          dst_pointer  <= dst_pointer + AW'(1);
          src_pointer  <= src_pointer + AW'(1);
        end
      end
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (in_acc) begin
        out_reg <= result_new;
      end
    end else if (in_acc) begin
      skid <= result_new;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.dst_addr     = out_reg.dst_addr;
  assign result_out.src_addr     = out_reg.src_addr;
  assign result_out.write_enable = out_reg.write_enable;
  assign result_out.write_data   = out_reg.write_data;
  assign result_out.last_pixel   = out_reg.last_pixel;

  `RBK_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid)
  `RBK_ASSERT_NEXT(a_stall_fills_skid, in_acc && out_valid && !result_out.ready, skid_valid)
  `RBK_ASSERT_SAME(a_column_in_range, 1'b1, {1'b0, column_count} < {1'b0, eff_width})
  `RBK_ASSERT_NEXT(a_last_restarts, in_acc && rect_end && !cfg_write,
                   column_count == '0 && row_count == '0 && dst_pointer == dst_start)

endmodule
